>>> src/drt_pkg.sv
`default_nettype none

package drt_pkg;

  // Field widths
  localparam int unsigned CoordW = 14;
  localparam int unsigned ImgPosW = 16;
  localparam int unsigned ImgDimW = 15;
  localparam int unsigned RowBytesW = 16;
  localparam int unsigned CfgAddrW = 2;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;
  typedef logic [CoordW-1:0] coord_t;

  // Request opcodes
  localparam op_t OP_IMAGE = 2'd0;
  localparam op_t OP_END_FRAME = 2'd1;
  localparam op_t OP_INVALIDATE = 2'd2;

  // Result status codes
  localparam status_t ST_UNCHANGED = 2'd0;
  localparam status_t ST_CHANGED = 2'd1;
  localparam status_t ST_NOT_READY = 2'd2;

  // Configuration register indexes
  localparam cfg_addr_t CFG_FRAME_WIDTH = 2'd0;
  localparam cfg_addr_t CFG_FRAME_HEIGHT = 2'd1;
  localparam cfg_addr_t CFG_TRACK_LOADED = 2'd2;

endpackage

`default_nettype wire

>>> src/drt_ifs.sv
`default_nettype none

// Image / end-of-frame request channel
interface drt_in_if;
  import drt_pkg::*;
  logic valid;
  logic ready;
  op_t op;
  logic signed [ImgPosW-1:0] img_x;
  logic signed [ImgPosW-1:0] img_y;
  logic [ImgDimW-1:0] img_width;
  logic [ImgDimW-1:0] img_height;
  logic frame_changed;

  modport source (output valid, op, img_x, img_y, img_width, img_height, frame_changed,
                  input ready);
  modport sink (input valid, op, img_x, img_y, img_width, img_height, frame_changed,
                output ready);
endinterface

// Dirty rectangle result channel
interface drt_out_if;
  import drt_pkg::*;
  logic valid;
  logic ready;
  status_t status;
  coord_t dirty_x;
  coord_t dirty_y;
  coord_t dirty_w;
  coord_t dirty_h;
  logic [RowBytesW-1:0] row_bytes;

  modport source (output valid, status, dirty_x, dirty_y, dirty_w, dirty_h, row_bytes,
                  input ready);
  modport sink (input valid, status, dirty_x, dirty_y, dirty_w, dirty_h, row_bytes,
                output ready);
endinterface

// Register write channel
interface drt_cfg_if;
  import drt_pkg::*;
  logic valid;
  logic ready;
  cfg_addr_t addr;
  coord_t data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> src/dirty_region_tracker_top.sv
`default_nettype none

// Overlay dirty-rectangle tracker.
// in_chan takes requests: image rectangles (clipped to the frame and merged
// into a running bounding box), end-of-frame markers carrying the renderer's
// changed flag, and invalidate (previous box becomes the whole frame).
// out_chan returns one result per end-of-frame request: status, the dirty
// rectangle (union of this frame's box and the previous one) and its bytes
// per row. Image and invalidate requests give no result.
// cfg_chan writes frame width, frame height and track-loaded; it is always
// ready and should be written only while the tracker is idle.
// A request is registered in the input stage, processed there, and its
// result is registered in the output register.
// Throughput: one request per cycle while no result is held up, the running
// box being updated combinationally. The output register frees the input side
// while a result waits; if the receiver stalls with a result pending, an
// end-of-frame request holds in the input stage and in_chan.ready drops.
// Reset clears the configuration registers, running box, previous box and all valid flags.
module dirty_region_tracker_top (
  input  wire logic clk,
  input  wire logic rst_n,
  drt_in_if.sink    in_chan,
  drt_out_if.source out_chan,
  drt_cfg_if.sink   cfg_chan
);
  import drt_pkg::*;

  localparam int unsigned SumW = ImgPosW + 2;

  // Configuration registers
  coord_t frame_w_r, frame_h_r;
  logic track_r;

  // Input stage
  logic s1_valid_r;
  op_t s1_op_r;
  logic signed [ImgPosW-1:0] s1_x_r, s1_y_r;
  logic [ImgDimW-1:0] s1_w_r, s1_h_r;
  logic s1_chg_r;

  // Tracker state
  coord_t acc_l_r, acc_t_r, acc_r_r, acc_b_r;
  coord_t prev_l_r, prev_t_r, prev_w_r, prev_h_r;
  coord_t acc_l_nxt, acc_t_nxt, acc_r_nxt, acc_b_nxt;
  coord_t prev_l_nxt, prev_t_nxt, prev_w_nxt, prev_h_nxt;

  // Output register
  logic out_valid_r;
  status_t out_status_r;
  coord_t out_x_r, out_y_r, out_w_r, out_h_r;
  status_t res_status;
  coord_t res_x, res_y, res_w, res_h;

  logic rdy, is_eof, out_free, s1_fire, in_fire;

  assign rdy = (frame_w_r != '0) && (frame_h_r != '0) && track_r;
  assign is_eof = (s1_op_r == OP_END_FRAME);
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_fire = s1_valid_r && (!is_eof || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Clip the image rectangle to the frame
  logic signed [SumW-1:0] ix, iy, x0, y0, x1s, y1s, x1, y1, fw, fh;
  logic img_ok;
  always_comb begin
    ix = {{2{s1_x_r[ImgPosW-1]}}, s1_x_r};
    iy = {{2{s1_y_r[ImgPosW-1]}}, s1_y_r};
    fw = SumW'(frame_w_r);
    fh = SumW'(frame_h_r);
    x0 = ix[SumW-1] ? '0 : ix;
    y0 = iy[SumW-1] ? '0 : iy;
    x1s = ix + SumW'(s1_w_r);
    y1s = iy + SumW'(s1_h_r);
    x1 = (x1s > fw) ? fw : x1s;
    y1 = (y1s > fh) ? fh : y1s;
    img_ok = (x1 > x0) && (y1 > y0);
  end

  // Previous box merged with the running box
  logic acc_empty, prev_set;
  logic [CoordW:0] pr, pb, dl, dt, dr, db, dw, dh;
  always_comb begin
    acc_empty = (acc_r_r <= acc_l_r) || (acc_b_r <= acc_t_r);
    prev_set = (prev_w_r != '0) && (prev_h_r != '0);
    pr = {1'b0, prev_l_r} + {1'b0, prev_w_r};
    pb = {1'b0, prev_t_r} + {1'b0, prev_h_r};
    dl = {1'b0, acc_l_r};
    dt = {1'b0, acc_t_r};
    dr = {1'b0, acc_r_r};
    db = {1'b0, acc_b_r};
    if (prev_set) begin
      if (acc_empty) begin
        dl = {1'b0, prev_l_r};
        dt = {1'b0, prev_t_r};
        dr = pr;
        db = pb;
      end else begin
        if ({1'b0, prev_l_r} < dl) dl = {1'b0, prev_l_r};
        if ({1'b0, prev_t_r} < dt) dt = {1'b0, prev_t_r};
        if (pr > dr) dr = pr;
        if (pb > db) db = pb;
      end
    end
    dw = (dr > dl) ? dr - dl : '0;
    dh = (db > dt) ? db - dt : '0;
  end

  // Next state and result
  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_t_nxt = acc_t_r;
    acc_r_nxt = acc_r_r;
    acc_b_nxt = acc_b_r;
    prev_l_nxt = prev_l_r;
    prev_t_nxt = prev_t_r;
    prev_w_nxt = prev_w_r;
    prev_h_nxt = prev_h_r;
    res_status = ST_UNCHANGED;
    res_x = '0;
    res_y = '0;
    res_w = '0;
    res_h = '0;
    unique case (s1_op_r)
      OP_IMAGE: begin
        if (rdy && img_ok) begin
          if (acc_empty) begin
            acc_l_nxt = x0[CoordW-1:0];
            acc_t_nxt = y0[CoordW-1:0];
            acc_r_nxt = x1[CoordW-1:0];
            acc_b_nxt = y1[CoordW-1:0];
          end else begin
            if (x0[CoordW-1:0] < acc_l_r) acc_l_nxt = x0[CoordW-1:0];
            if (y0[CoordW-1:0] < acc_t_r) acc_t_nxt = y0[CoordW-1:0];
            if (x1[CoordW-1:0] > acc_r_r) acc_r_nxt = x1[CoordW-1:0];
            if (y1[CoordW-1:0] > acc_b_r) acc_b_nxt = y1[CoordW-1:0];
          end
        end
      end
      OP_END_FRAME: begin
        acc_l_nxt = '0;
        acc_t_nxt = '0;
        acc_r_nxt = '0;
        acc_b_nxt = '0;
        if (!rdy) begin
          res_status = ST_NOT_READY;
        end else if (s1_chg_r) begin
          res_status = ST_CHANGED;
          prev_l_nxt = acc_l_r;
          prev_t_nxt = acc_t_r;
          prev_w_nxt = (acc_r_r > acc_l_r) ? acc_r_r - acc_l_r : '0;
          prev_h_nxt = (acc_b_r > acc_t_r) ? acc_b_r - acc_t_r : '0;
          if (dw != '0 && dh != '0) begin
            res_x = dl[CoordW-1:0];
            res_y = dt[CoordW-1:0];
            res_w = dw[CoordW-1:0];
            res_h = dh[CoordW-1:0];
          end
        end
      end
      OP_INVALIDATE: begin
        prev_l_nxt = '0;
        prev_t_nxt = '0;
        prev_w_nxt = frame_w_r;
        prev_h_nxt = frame_h_r;
      end
      default: begin
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= '0;
      frame_h_r <= '0;
      track_r <= 1'b0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_l_r <= '0;
      acc_t_r <= '0;
      acc_r_r <= '0;
      acc_b_r <= '0;
      prev_l_r <= '0;
      prev_t_r <= '0;
      prev_w_r <= '0;
      prev_h_r <= '0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.addr)
          CFG_FRAME_WIDTH: frame_w_r <= cfg_chan.data;
          CFG_FRAME_HEIGHT: frame_h_r <= cfg_chan.data;
          CFG_TRACK_LOADED: track_r <= cfg_chan.data[0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && is_eof) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        acc_l_r <= acc_l_nxt;
        acc_t_r <= acc_t_nxt;
        acc_r_r <= acc_r_nxt;
        acc_b_r <= acc_b_nxt;
        prev_l_r <= prev_l_nxt;
        prev_t_r <= prev_t_nxt;
        prev_w_r <= prev_w_nxt;
        prev_h_r <= prev_h_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_chan.op;
      s1_x_r <= in_chan.img_x;
      s1_y_r <= in_chan.img_y;
      s1_w_r <= in_chan.img_width;
      s1_h_r <= in_chan.img_height;
      s1_chg_r <= in_chan.frame_changed;
    end
    if (s1_fire && is_eof) begin
      out_status_r <= res_status;
      out_x_r <= res_x;
      out_y_r <= res_y;
      out_w_r <= res_w;
      out_h_r <= res_h;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.dirty_x = out_x_r;
  assign out_chan.dirty_y = out_y_r;
  assign out_chan.dirty_w = out_w_r;
  assign out_chan.dirty_h = out_h_r;
  // Four bytes per pixel
  assign out_chan.row_bytes = {out_w_r, 2'b00};

endmodule

`default_nettype wire
